>>> src/dsde_pkg.sv
// types, constants and font functions for the decimal segment display encoder
// used by decimal_segment_display_encoder; depends on nothing else
package dsde_pkg;

    typedef struct packed {
        logic        kind;
        logic [31:0] number_value;
        logic [7:0]  char_code;
        logic [2:0]  char_position;
    } t_in_item;

    typedef struct packed {
        logic [2:0] digit_index;
        logic [7:0] segments_first;
        logic [7:0] segments_second;
        logic       overflow_shown;
        logic       last_write;
    } t_out_item;

    localparam logic KIND_NUMBER = 1'b0;
    localparam logic KIND_CHAR   = 1'b1;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_Z     = 8'h5A;
    localparam logic [7:0] CHAR_E     = 8'h45;
    localparam logic [7:0] CHAR_O     = 8'h4F;
    localparam logic [7:0] CHAR_R     = 8'h52;

    localparam logic [7:0] SEG_ALL = 8'hFF;

    // {first byte, second byte}
    localparam logic [15:0] FONT_DIGITS [10] = '{
        16'hFC28, 16'h6020, 16'hDB00, 16'hF300, 16'h6700,
        16'hB700, 16'hBF00, 16'hE400, 16'hFF00, 16'hF700
    };

    localparam logic [15:0] FONT_LETTERS [26] = '{
        16'hEF00, 16'hF150, 16'h9C00, 16'hF050, 16'h9F00,
        16'h8F00, 16'hBD00, 16'h6F00, 16'h9050, 16'h7800,
        16'h0E22, 16'h1C00, 16'h6CA0, 16'h6C82, 16'hFC00,
        16'hCF00, 16'hFC02, 16'hCF02, 16'hB700, 16'h8050,
        16'h7C00, 16'h0C28, 16'h6C0A, 16'h00AA, 16'h00B0,
        16'h9028
    };

    // power of ten, evaluated at elaboration
    function automatic logic [31:0] pow10(input int unsigned n);
        logic [31:0] acc;
        acc = 32'd1;
        for (int unsigned i = 0; i < n; i++) begin
            acc = acc * 32'd10;
        end
        return acc;
    endfunction

    // letter of the error text counted from its right end, space beyond it
    function automatic logic [7:0] error_char(input logic [2:0] k);
        logic [7:0] c;
        unique case (k)
            3'd0, 3'd2, 3'd3: c = CHAR_R;
            3'd1:             c = CHAR_O;
            3'd4:             c = CHAR_E;
            default:          c = CHAR_SPACE;
        endcase
        return c;
    endfunction

    // character code to {first, second} segment bytes
    function automatic logic [15:0] font_seg(input logic [7:0] code);
        logic [15:0] seg;
        logic [7:0]  ofs_d;
        logic [7:0]  ofs_l;
        ofs_d = code - CHAR_ZERO;
        ofs_l = code - CHAR_A;
        if (code == CHAR_SPACE) begin
            seg = 16'h0000;
        end else if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
            seg = FONT_DIGITS[ofs_d[3:0]];
        end else if (code >= CHAR_A && code <= CHAR_Z) begin
            seg = FONT_LETTERS[ofs_l[4:0]];
        end else begin
            seg = {SEG_ALL, SEG_ALL};
        end
        return seg;
    endfunction

endpackage

>>> src/decimal_segment_display_encoder.sv
// decimal segment display encoder: number or character in, segment beats by digit position out
// depends on dsde_pkg for the beat types, font and error text
//
//  channel  direction  handshake             payload
//  input    in         i_valid / o_ready     i_data  (dsde_pkg::t_in_item)
//  output   out        o_valid / i_ready     o_data  (dsde_pkg::t_out_item)
//
// four register stages: input capture with range check, digit engine, character
// register, font lookup into the output register; characters stream one per
// cycle while i_ready does not stall, and a number gives DIGIT_COUNT digits, one
// digit per cycle from the digit engine unless i_ready stalls; a character whose
// position is at or beyond DIGIT_COUNT is taken and dropped
// synchronous active-low reset clears the valid bits only; a stall on i_ready
// holds each stage whose next stage is full and back-pressures o_ready with
// nothing lost or repeated
module decimal_segment_display_encoder #(
    parameter int DIGIT_COUNT = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  dsde_pkg::t_in_item   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output dsde_pkg::t_out_item  o_data
);

    localparam logic [31:0] LIMIT    = dsde_pkg::pow10(DIGIT_COUNT);
    localparam logic [31:0] SCALE    = dsde_pkg::pow10(DIGIT_COUNT - 1);
    localparam int          VW       = $clog2(LIMIT);
    localparam logic [2:0]  LAST_POS = 3'(DIGIT_COUNT - 1);

    // stage 1: captured beat
    logic             r1_valid;
    logic             r1_kind;
    logic             r1_ovf;
    logic [VW-1:0]    r1_value;
    logic [7:0]       r1_code;
    logic [2:0]       r1_pos;

    // stage 2: digit engine
    logic             r2_busy;
    logic             r2_kind;
    logic             r2_ovf;
    logic             r2_seen;
    logic [VW-1:0]    r2_rem;
    logic [2:0]       r2_cnt;
    logic [7:0]       r2_code;
    logic [2:0]       r2_cpos;

    // stage 3: character register
    logic             r3_valid;
    logic [2:0]       r3_pos;
    logic [7:0]       r3_code;
    logic             r3_ovf;
    logic             r3_last;

    // stage 4: output register
    logic                 r4_valid;
    dsde_pkg::t_out_item  r4_data;

    logic             n_r1_keep;
    logic             s4_free;
    logic             s3_free;
    logic             e_fire;
    logic             e_done;
    logic             s1_take;
    logic [3:0]       e_digit;
    logic [VW+3:0]    e_sub;
    logic [VW+3:0]    e_rem10;
    logic [VW-1:0]    n_rem;
    logic             e_blank;
    logic [7:0]       e_code;
    logic [2:0]       e_pos;
    logic             e_last;
    logic [15:0]      f_seg;

    assign s4_free = !r4_valid || i_ready;
    assign s3_free = !r3_valid || s4_free;
    assign e_fire  = r2_busy && s3_free;
    assign e_done  = e_fire && e_last;
    assign s1_take = r1_valid && (!r2_busy || e_done);
    assign o_ready = !r1_valid || s1_take;

    // out-of-range character positions never enter the pipe
    assign n_r1_keep = i_valid && !(i_data.kind == dsde_pkg::KIND_CHAR
                                    && 32'(i_data.char_position) >= 32'(DIGIT_COUNT));

    // leading digit of the remainder against fixed multiples of the top scale
    always_comb begin
        e_digit = 4'd0;
        e_sub   = '0;
        for (int k = 1; k < 10; k++) begin
            if (r2_rem >= VW'(SCALE * k)) begin
                e_digit = 4'(k);
                e_sub   = (VW+4)'(LIMIT * k);
            end
        end
        e_rem10 = {1'b0, r2_rem, 3'b000} + {3'b000, r2_rem, 1'b0};
        n_rem   = VW'(e_rem10 - e_sub);
    end

    always_comb begin
        e_blank = (r2_cnt != LAST_POS) && (e_digit == 4'd0) && !r2_seen;
        if (r2_kind == dsde_pkg::KIND_CHAR) begin
            e_code = r2_code;
            e_pos  = r2_cpos;
            e_last = 1'b1;
        end else begin
            e_pos  = r2_cnt;
            e_last = (r2_cnt == LAST_POS);
            if (r2_ovf) begin
                e_code = dsde_pkg::error_char(LAST_POS - r2_cnt);
            end else if (e_blank) begin
                e_code = dsde_pkg::CHAR_SPACE;
            end else begin
                e_code = dsde_pkg::CHAR_ZERO + {4'd0, e_digit};
            end
        end
    end

    assign f_seg = dsde_pkg::font_seg(r3_code);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_busy  <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r1_valid <= n_r1_keep;
            end
            if (s1_take) begin
                r2_busy <= 1'b1;
            end else if (e_done) begin
                r2_busy <= 1'b0;
            end
            if (s3_free) begin
                r3_valid <= e_fire;
            end
            if (s4_free) begin
                r4_valid <= r3_valid;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r1_kind  <= i_data.kind;
            r1_ovf   <= (i_data.number_value >= LIMIT);
            r1_value <= i_data.number_value[VW-1:0];
            r1_code  <= i_data.char_code;
            r1_pos   <= i_data.char_position;
        end
        if (s1_take) begin
            r2_kind <= r1_kind;
            r2_ovf  <= r1_ovf;
            r2_rem  <= r1_value;
            r2_seen <= 1'b0;
            r2_cnt  <= 3'd0;
            r2_code <= r1_code;
            r2_cpos <= r1_pos;
        end else if (e_fire) begin
            r2_rem  <= n_rem;
            r2_seen <= r2_seen || !e_blank;
            r2_cnt  <= r2_cnt + 3'd1;
        end
        if (s3_free) begin
            r3_pos  <= e_pos;
            r3_code <= e_code;
            r3_ovf  <= (r2_kind == dsde_pkg::KIND_NUMBER) && r2_ovf;
            r3_last <= e_last;
        end
        if (s4_free) begin
            r4_data.digit_index     <= r3_pos;
            r4_data.segments_first  <= f_seg[15:8];
            r4_data.segments_second <= f_seg[7:0];
            r4_data.overflow_shown  <= r3_ovf;
            r4_data.last_write      <= r3_last;
        end
    end

    assign o_valid = r4_valid;
    assign o_data  = r4_data;

endmodule
